### src/mandelbrot_escape_time_core_assert.svh
// Assertion macros used by the checker of the escape-time core.
// Both expect signals named clk and rst in the scope where they are used.
`ifndef MANDELBROT_ESCAPE_TIME_CORE_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_CORE_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define MBET_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high.
`define MBET_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/mbet_pkg.sv
`default_nettype none

package mbet_pkg;

  localparam int FRAC_BITS = 28;
  localparam int ZW = 32;
  localparam int PW = 2 * ZW;
  localparam int CW = 16;
  localparam int GW = 8;

  localparam int ESC_SHIFT = 2 * FRAC_BITS + 2;
  localparam bit ESC_REACHABLE = (ESC_SHIFT <= PW - 1);
  localparam logic [PW-1:0] ESC_LIMIT = ESC_REACHABLE ? (PW'(1) << ESC_SHIFT) : '0;

  // half an ulp for the real and the doubled imaginary part
  localparam logic signed [PW-1:0] RR_HALF = PW'(1) << (FRAC_BITS - 1);
  localparam logic signed [PW-1:0] RI_HALF = PW'(1) << (FRAC_BITS - 2);

  localparam logic [CW-1:0] MAX_ITER_RESET = CW'(2000);

  typedef struct packed {
    logic signed [ZW-1:0] c_real;
    logic signed [ZW-1:0] c_imag;
  } in_item_t;

  typedef struct packed {
    logic [CW-1:0] iteration_count;
    logic [GW-1:0] gray_level;
  } out_item_t;

  typedef struct packed {
    logic [CW-1:0] count;
    logic [CW-1:0] limit;
  } grade_req_t;

  typedef struct packed {
    logic [CW-1:0] rem;
    logic [GW-1:0] low;
    logic [GW-1:0] quo;
    logic [CW-1:0] den;
    logic [CW-1:0] count;
  } div_t;

endpackage

`default_nettype wire

### src/mbet_iter.sv
`default_nettype none

module mbet_iter (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  mbet_pkg::in_item_t     in_data,
  input  logic [mbet_pkg::CW-1:0] max_iterations,
  output logic                   req_valid,
  input  logic                   req_ready,
  output mbet_pkg::grade_req_t   req
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_ADD  = 5'b00100,
    S_RND  = 5'b01000,
    S_DONE = 5'b10000
  } iter_state_t;

  function automatic logic signed [mbet_pkg::ZW-1:0] sat_z(
    input logic signed [mbet_pkg::PW-1:0] v
  );
    logic [mbet_pkg::PW-mbet_pkg::ZW:0] top;
    top = v[mbet_pkg::PW-1:mbet_pkg::ZW-1];
    if (top == '0 || top == '1) begin
      sat_z = v[mbet_pkg::ZW-1:0];
    end else if (v[mbet_pkg::PW-1]) begin
      sat_z = {1'b1, {(mbet_pkg::ZW-1){1'b0}}};
    end else begin
      sat_z = {1'b0, {(mbet_pkg::ZW-1){1'b1}}};
    end
  endfunction

  iter_state_t state;
  iter_state_t state_next;

  logic signed [mbet_pkg::ZW-1:0] cr, ci, zr, zi;
  logic signed [mbet_pkg::PW-1:0] rr, ii, ri;
  logic signed [mbet_pkg::PW-1:0] re_acc, im_acc;
  logic [mbet_pkg::CW-1:0]        cnt;
  logic                           first;

  logic signed [mbet_pkg::PW-1:0] rr_prod, ii_prod, ri_prod;
  logic [mbet_pkg::PW-1:0]        mag;
  logic                           escape;
  logic [mbet_pkg::CW-1:0]        cnt_inc;
  logic signed [mbet_pkg::PW-1:0] re_sum, im_sum;

  assign rr_prod = zr * zr;
  assign ii_prod = zi * zi;
  assign ri_prod = zr * zi;

  // the squares of z double as the escape test of the z they came from
  assign mag     = $unsigned(rr) + $unsigned(ii);
  assign escape  = mbet_pkg::ESC_REACHABLE && !first && (mag >= mbet_pkg::ESC_LIMIT);
  assign cnt_inc = cnt + mbet_pkg::CW'(1);

  // keep both operands signed so the shift stays arithmetic
  assign re_sum = (re_acc >>> mbet_pkg::FRAC_BITS)
                + $signed({{(mbet_pkg::PW-mbet_pkg::ZW){cr[mbet_pkg::ZW-1]}}, cr});
  assign im_sum = (im_acc >>> (mbet_pkg::FRAC_BITS - 1))
                + $signed({{(mbet_pkg::PW-mbet_pkg::ZW){ci[mbet_pkg::ZW-1]}}, ci});

  assign in_ready  = (state == S_IDLE);
  assign req_valid = (state == S_DONE);
  assign req.count = cnt;
  assign req.limit = max_iterations;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (max_iterations == '0) ? S_DONE : S_MUL;
        end
      end
      S_MUL: state_next = S_ADD;
      S_ADD: begin
        if (escape || (!first && cnt_inc == max_iterations)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_RND;
        end
      end
      S_RND: state_next = S_MUL;
      S_DONE: begin
        if (req_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cr    <= in_data.c_real;
          ci    <= in_data.c_imag;
          zr    <= '0;
          zi    <= '0;
          cnt   <= '0;
          first <= 1'b1;
        end
      end
      S_MUL: begin
        rr <= rr_prod;
        ii <= ii_prod;
        ri <= ri_prod;
      end
      S_ADD: begin
        // the z just tested stayed inside: count it
        if (!first && !escape) begin
          cnt <= cnt_inc;
        end
        first  <= 1'b0;
        re_acc <= rr - ii + mbet_pkg::RR_HALF;
        im_acc <= ri + mbet_pkg::RI_HALF;
      end
      S_RND: begin
        zr <= sat_z(re_sum);
        zi <= sat_z(im_sum);
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### src/mbet_div_cell.sv
`default_nettype none

module mbet_div_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  mbet_pkg::div_t in_stage,
  output logic           out_valid,
  output mbet_pkg::div_t out_stage
);

  logic [mbet_pkg::CW:0]   trial;
  logic [mbet_pkg::CW:0]   diff;
  logic                    fits;
  mbet_pkg::div_t          stage_next;

  // bring down the next numerator bit and try one subtract
  assign trial = {in_stage.rem, in_stage.low[mbet_pkg::GW-1]};
  assign diff  = trial - {1'b0, in_stage.den};
  assign fits  = (trial >= {1'b0, in_stage.den});

  always_comb begin
    stage_next       = in_stage;
    stage_next.rem   = fits ? diff[mbet_pkg::CW-1:0] : trial[mbet_pkg::CW-1:0];
    stage_next.low   = {in_stage.low[mbet_pkg::GW-2:0], 1'b0};
    stage_next.quo   = {in_stage.quo[mbet_pkg::GW-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_stage <= stage_next;
  end

endmodule

`default_nettype wire

### src/mbet_gray.sv
`default_nettype none

module mbet_gray (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  mbet_pkg::grade_req_t req,
  output logic                 busy,
  output logic                 res_valid,
  output mbet_pkg::out_item_t  res
);

  logic [mbet_pkg::CW-1:0]         remain;
  logic [mbet_pkg::CW+mbet_pkg::GW-1:0] num;
  logic [mbet_pkg::GW:0]           vld;
  mbet_pkg::div_t                  stage [mbet_pkg::GW+1];

  // 255 * remaining as a shift and subtract; the quotient stays below 256
  assign remain = req.limit - req.count;
  assign num    = {remain, {mbet_pkg::GW{1'b0}}}
                - {{mbet_pkg::GW{1'b0}}, remain};

  always_comb begin
    stage[0].rem   = num[mbet_pkg::CW+mbet_pkg::GW-1:mbet_pkg::GW];
    stage[0].low   = num[mbet_pkg::GW-1:0];
    stage[0].quo   = '0;
    // zero limit: divide zero by one so the level comes out zero
    stage[0].den   = (req.limit == '0) ? mbet_pkg::CW'(1) : req.limit;
    stage[0].count = req.count;
  end

  assign vld[0] = req_valid;

  for (genvar i = 0; i < mbet_pkg::GW; i++) begin : g_cell
    mbet_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[i]),
      .in_stage  (stage[i]),
      .out_valid (vld[i+1]),
      .out_stage (stage[i+1])
    );
  end

  assign busy                = |vld[mbet_pkg::GW:1];
  assign res_valid           = vld[mbet_pkg::GW];
  assign res.iteration_count = stage[mbet_pkg::GW].count;
  assign res.gray_level      = stage[mbet_pkg::GW].quo;

endmodule

`default_nettype wire

### src/mandelbrot_escape_time_core.sv
// Mandelbrot escape-time core.
// Input channel (in_valid/in_ready/in_data): one point c, real and imaginary
// parts in signed Q4.28. Output channel (out_valid/out_ready/out_data): the
// iteration count and the gray level for that point, one item per input.
// Config channel (cfg_valid/cfg_ready/cfg_data): writes max_iterations; it is
// always ready and should be written only while no item is in flight.
// One point is iterated at a time. Each iteration of z = z*z + c runs
// through three 32x32 multipliers, an add stage and a round/saturate
// stage. The gray level then runs through a row of 8 divider cells, one
// quotient bit per cell.
// A new point is accepted once the previous one has entered the divider row,
// so the next point iterates while a finished result waits on the output.
// If the receiver stalls, the result holds in the output register and the
// next finished point waits ahead of the divider row.
// Reset clears all control and loads max_iterations with 2000.
`default_nettype none

module mandelbrot_escape_time_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  mbet_pkg::in_item_t      in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output mbet_pkg::out_item_t     out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [mbet_pkg::CW-1:0] cfg_data
);

  logic [mbet_pkg::CW-1:0] max_iterations;
  logic                    req_valid;
  logic                    req_ready;
  mbet_pkg::grade_req_t    req;
  logic                    gray_busy;
  logic                    res_valid;
  mbet_pkg::out_item_t     res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= mbet_pkg::MAX_ITER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_iterations <= cfg_data;
    end
  end

  mbet_iter u_iter (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .max_iterations (max_iterations),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .req            (req)
  );

  // hand off only into an empty row with a free output slot
  assign req_ready = !gray_busy && !out_valid;

  mbet_gray u_gray (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid && req_ready),
    .req       (req),
    .busy      (gray_busy),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

### src/mbet_checker.sv
`default_nettype none

`include "mandelbrot_escape_time_core_assert.svh"

module mbet_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input mbet_pkg::out_item_t out_data
);

  `MBET_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output item changed or dropped while stalled")

  `MBET_ASSERT_NEXT(a_one_point, in_valid && in_ready, !in_ready, "second point taken while one is iterating")

  `MBET_ASSERT_NEXT(a_no_refill, out_valid && out_ready, !out_valid, "output refilled right after an item was taken")

  `MBET_ASSERT_IMPL(a_reset_idle, $fell(rst), !out_valid && in_ready, "block not idle after reset")

endmodule

bind mandelbrot_escape_time_core mbet_checker u_mbet_checker (.*);

`default_nettype wire
